@@ rtl/core/gec_pkg.sv @@
// ----------------------------------------------------------------------------
// gec_pkg
// Shared types and codes for the complex gabor energy convolver.
// ----------------------------------------------------------------------------
package gec_pkg;

  // store geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_KERNEL = 16;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD_KERNEL = 2'd0,
    CMD_LOAD_PIXEL  = 2'd1,
    CMD_COMPUTE     = 2'd2,
    CMD_NONE        = 2'd3
  } gec_cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SIDE   = 2'd2,
    REG_SPARE  = 2'd3
  } gec_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_MAC,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } gec_state_t;

  localparam int AccW = 48;

endpackage

@@ rtl/core/gec_isqrt.sv @@
// ----------------------------------------------------------------------------
// gec_isqrt
// Bit-pair iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gec_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import gec_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] trial;
  logic [65:0] shifted;

  // one restoring step per cycle
  always_comb begin
    shifted  = {rem_r, rad_r[63:62]};
    trial    = shifted - {32'd0, root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rad_nxt  = rad_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      rad_nxt  = radicand;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (!trial[65]) begin
        rem_nxt  = trial[63:0];
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = shifted[63:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign root = root_nxt;

endmodule

@@ rtl/core/gabor_energy_convolver.sv @@
// ----------------------------------------------------------------------------
// gabor_energy_convolver
// Complex gabor filter energy at one output pixel of a loaded image.
// ----------------------------------------------------------------------------
// Usage: words arrive on in_* (valid/ready). Load kernel and load pixel words
// write the kernel or image memory and give no result, so loads can follow
// each other every cycle. A compute word walks all side*side kernel taps
// through one shared complex multiply-accumulate, each tap a memory read
// then a MAC step, then a step squaring the sums, a launch and bit-serial
// square root steps, one per root bit. The energy word then appears on
// out_*; when a sum saturates, the root is skipped and it is 0xFFFF. The
// block takes the next word in the cycle after the energy word leaves.
// The energy word waits in an output register on out_*; the block takes no
// new word until it is accepted, so a stalled receiver stalls the input.
// Configuration words on cfg_* are taken at any time and meant for idle.
// Reset clears the sequencer and restores width 64, height 64, side 16;
// memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module gabor_energy_convolver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [15:0] in_pixel_value,
  input  logic signed [15:0] in_coef_real,
  input  logic signed [15:0] in_coef_imag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_energy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import gec_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int KW = $clog2(MAX_KERNEL) > 0 ? $clog2(MAX_KERNEL) : 1;

  gec_state_t state_r, state_nxt;
  logic [6:0] width_r, height_r;
  logic [4:0] side_r;
  logic [15:0] img_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [15:0] kre_mem [MAX_KERNEL*MAX_KERNEL];
  logic [15:0] kim_mem [MAX_KERNEL*MAX_KERNEL];
  logic [5:0] b_r, a_r;
  logic [4:0] j_r, j_nxt, i_r, i_nxt;
  logic signed [AccW-1:0] accr_r, accr_nxt, acci_r, acci_nxt;
  logic [15:0] pix_rd_r, kre_rd_r, kim_rd_r;
  logic tap_ok_r;
  logic [63:0] sq_r, sq_nxt;
  logic [15:0] energy_r, energy_nxt;
  logic sq_start, sq_done;
  logic [31:0] root;
  logic ovf;

  // effective configuration
  logic [6:0] w_eff, h_eff;
  logic [4:0] s_eff, off;
  assign w_eff = (width_r > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_r;
  assign s_eff = (side_r > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : side_r;
  assign off   = 5'((6'(s_eff) + 6'd1) >> 1);

  // tap coordinates
  logic signed [8:0] y, x;
  logic tap_ok;
  assign y = $signed({3'd0, b_r}) + $signed({4'd0, off}) - $signed({4'd0, j_r});
  assign x = $signed({3'd0, a_r}) + $signed({4'd0, off}) - $signed({4'd0, i_r});
  assign tap_ok = (y >= 0) && (y < $signed({2'd0, h_eff})) &&
                  (x >= 0) && (x < $signed({2'd0, w_eff}));

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_energy = energy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
      side_r   <= 5'd16;
    end else if (cfg_valid) begin
      unique case (gec_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_SIDE:   side_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // memories: loads and tap reads
  logic in_fire;
  assign in_fire = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (in_fire && gec_cmd_t'(in_command) == CMD_LOAD_KERNEL &&
        32'(in_row) < MAX_KERNEL && 32'(in_col) < MAX_KERNEL) begin
      kre_mem[{KW'(in_row), KW'(in_col)}] <= in_coef_real;
      kim_mem[{KW'(in_row), KW'(in_col)}] <= in_coef_imag;
    end
    if (in_fire && gec_cmd_t'(in_command) == CMD_LOAD_PIXEL &&
        32'(in_row) < MAX_HEIGHT && 32'(in_col) < MAX_WIDTH)
      img_mem[{YW'(in_row), XW'(in_col)}] <= in_pixel_value;
    pix_rd_r <= img_mem[{YW'(y), XW'(x)}];
    kre_rd_r <= kre_mem[{KW'(j_r), KW'(i_r)}];
    kim_rd_r <= kim_mem[{KW'(j_r), KW'(i_r)}];
    tap_ok_r <= tap_ok;
    if (in_fire) begin
      b_r <= in_row;
      a_r <= in_col;
    end
  end

  // shared complex mac
  logic signed [33:0] pr, pi;
  assign pr = $signed({1'b0, pix_rd_r}) * $signed(kre_rd_r);
  assign pi = $signed({1'b0, pix_rd_r}) * $signed(kim_rd_r);

  // squaring of saturated-checked sums
  localparam logic signed [AccW-1:0] Lim = AccW'(64'sd2147483648);
  logic [31:0] ar, ai;
  assign ovf = (accr_r >= Lim) || (accr_r <= -Lim) || (acci_r >= Lim) || (acci_r <= -Lim);
  assign ar = accr_r[AccW-1] ? 32'(-accr_r) : 32'(accr_r);
  assign ai = acci_r[AccW-1] ? 32'(-acci_r) : 32'(acci_r);

  gec_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_r),
    .done     (sq_done),
    .root     (root)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    accr_nxt   = accr_r;
    acci_nxt   = acci_r;
    sq_nxt     = sq_r;
    energy_nxt = energy_r;
    sq_start   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && gec_cmd_t'(in_command) == CMD_COMPUTE) begin
          j_nxt = '0;
          i_nxt = '0;
          accr_nxt = '0;
          acci_nxt = '0;
          state_nxt = (s_eff == 5'd0) ? ST_SQUARE : ST_TAP;
        end
      end
      ST_TAP: state_nxt = ST_MAC;
      ST_MAC: begin
        if (tap_ok_r) begin
          accr_nxt = accr_r + AccW'(pr);
          acci_nxt = acci_r + AccW'(pi);
        end
        if (i_r == s_eff - 5'd1) begin
          i_nxt = '0;
          j_nxt = j_r + 5'd1;
          state_nxt = (j_r == s_eff - 5'd1) ? ST_SQUARE : ST_TAP;
        end else begin
          i_nxt = i_r + 5'd1;
          state_nxt = ST_TAP;
        end
      end
      ST_SQUARE: begin
        if (ovf) begin
          energy_nxt = 16'hFFFF;
          state_nxt = ST_OUT;
        end else begin
          sq_nxt = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        sq_start = (sq_r != 64'hFFFF_FFFF_FFFF_FFFF) && !sq_done && (j_r != 5'd31);
        j_nxt = 5'd31;
        if (sq_done) begin
          energy_nxt = (root[31] != 1'b0) ? 16'hFFFF : root[30:15];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    accr_r   <= accr_nxt;
    acci_r   <= acci_nxt;
    sq_r     <= sq_nxt;
    energy_r <= energy_nxt;
  end

  // checks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy))
    else $error("energy word changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_ROOT || $past(state_r) == ST_SQUARE)
    else $error("result without computation");

endmodule
